[design/bcd_pkg.sv]
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the bounding box center and diagonal block.
// ----------------------------------------------------------------------------
package bcd_pkg;

	// number of spatial axes handled per point
	localparam int NumAxes = 3;

	// back end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_ROOT,
		BK_HOLD
	} bk_state_t;

endpackage

[design/bounding_box_center_diagonal_top.sv]
// ----------------------------------------------------------------------------
// bounding_box_center_diagonal_top
// Running 3D axis-aligned bounding box with center and diagonal per set.
// ----------------------------------------------------------------------------
// Points are taken one per clock while full is low. The last point of a set
// hands its box to a two-entry queue; the back end then squares the three
// extents on one shared multiplier and runs a square root that resolves one
// result bit per cycle. full rises only when two finished sets are still
// waiting for the back end, and a result stays on the output until popped.
module bounding_box_center_diagonal_top #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic                          last_point,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_WIDTH-1:0] center_x,
	output logic signed [COORD_WIDTH-1:0] center_y,
	output logic signed [COORD_WIDTH-1:0] center_z,
	output logic [COORD_WIDTH:0]          diagonal
);

	localparam int BoxWidth = 2 * bcd_pkg::NumAxes * COORD_WIDTH;

	logic                                         in_xfer;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] pt;
	logic                                         box_push;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] box_min_w;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] box_max_w;
	logic [BoxWidth-1:0]                          q_rd;
	logic                                         q_empty;
	logic                                         q_pop;
	logic                                         res_valid;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] res_center;

	// input transfer
	assign in_xfer = push && !full;
	assign pt[0]   = point_x;
	assign pt[1]   = point_y;
	assign pt[2]   = point_z;

	bcd_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_xfer    (in_xfer),
		.pt         (pt),
		.last_point (last_point),
		.box_push   (box_push),
		.box_min    (box_min_w),
		.box_max    (box_max_w)
	);

	bcd_queue #(
		.DATA_WIDTH (BoxWidth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (box_push),
		.wr_data ({box_max_w, box_min_w}),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (full),
		.empty   (q_empty)
	);

	bcd_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.box_avail  (!q_empty),
		.box_min    (q_rd[BoxWidth/2-1:0]),
		.box_max    (q_rd[BoxWidth-1:BoxWidth/2]),
		.box_pop    (q_pop),
		.res_pop    (pop),
		.res_valid  (res_valid),
		.res_center (res_center),
		.res_diag   (diagonal)
	);

	// result side
	assign empty    = !res_valid;
	assign center_x = res_center[0];
	assign center_y = res_center[1];
	assign center_z = res_center[2];

endmodule

[design/bcd_front.sv]
// ----------------------------------------------------------------------------
// bcd_front
// Point intake: keeps the running per-axis minimum and maximum of the current
// set and hands the finished box to the set queue on the last point.
// ----------------------------------------------------------------------------
module bcd_front #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               in_xfer,
	input  logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0]       pt,
	input  logic                                               last_point,
	output logic                                               box_push,
	output logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0]       box_min,
	output logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0]       box_max
);

	logic                                         have_q;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] min_q;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] max_q;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] min_n;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] max_n;

	// per-axis compare, first point of a set loads both bounds
	always_comb begin
		for (int a = 0; a < bcd_pkg::NumAxes; a++) begin
			if (!have_q) begin
				min_n[a] = pt[a];
				max_n[a] = pt[a];
			end else begin
				min_n[a] = ($signed(pt[a]) < $signed(min_q[a])) ? pt[a] : min_q[a];
				max_n[a] = ($signed(pt[a]) > $signed(max_q[a])) ? pt[a] : max_q[a];
			end
		end
	end

	// box leaves with the last point of the set
	assign box_push = in_xfer && last_point;
	assign box_min  = min_n;
	assign box_max  = max_n;

	// set tracking, cleared once the box is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (in_xfer) begin
			have_q <= !last_point;
		end
	end

	// bounds
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			min_q <= min_n;
			max_q <= max_n;
		end
	end

endmodule

[design/bcd_queue.sv]
// ----------------------------------------------------------------------------
// bcd_queue
// Two-entry queue of finished boxes between the point intake and the
// arithmetic back end.
// ----------------------------------------------------------------------------
module bcd_queue #(
	parameter int DATA_WIDTH = 144
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic                  pop,
	output logic [DATA_WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	logic [DATA_WIDTH-1:0] mem_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)      count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

[design/bcd_back.sv]
// ----------------------------------------------------------------------------
// bcd_back
// Box arithmetic: centers, squared extents through one shared multiplier,
// a bit-per-cycle square root, and the result register.
// ----------------------------------------------------------------------------
module bcd_back #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 12
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         box_avail,
	input  logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] box_min,
	input  logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] box_max,
	output logic                                         box_pop,
	input  logic                                         res_pop,
	output logic                                         res_valid,
	output logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] res_center,
	output logic [COORD_WIDTH:0]                         res_diag
);

	localparam int SumWidth  = 2 * COORD_WIDTH + 2;
	localparam int RemWidth  = COORD_WIDTH + 3;
	localparam int IterWidth = $clog2(COORD_WIDTH + 1);
	localparam logic [COORD_WIDTH:0] DiagMin = {{COORD_WIDTH{1'b0}}, 1'b1} << FRAC_BITS;

	bcd_pkg::bk_state_t state_q, state_n;

	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] center_q;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] ext_q;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] center_n;
	logic [bcd_pkg::NumAxes-1:0][COORD_WIDTH-1:0] ext_n;
	logic [1:0]                 sq_cnt_q;
	logic [COORD_WIDTH-1:0]     mul_op;
	logic [2*COORD_WIDTH-1:0]   prod_q;
	logic [SumWidth-1:0]        acc_q;
	logic [SumWidth-1:0]        sum_q;
	logic [RemWidth-1:0]        rem_q;
	logic [RemWidth-1:0]        rem_n;
	logic [RemWidth-1:0]        trial;
	logic [COORD_WIDTH:0]       root_q;
	logic [IterWidth-1:0]       iter_q;
	logic                       load_box;
	logic                       load_res;
	logic                       res_valid_q;
	logic [COORD_WIDTH:0]       diag_n;

	// centers and extents straight from the queue head
	always_comb begin
		logic [COORD_WIDTH:0] s;
		logic [COORD_WIDTH:0] d;
		for (int a = 0; a < bcd_pkg::NumAxes; a++) begin
			s = {box_min[a][COORD_WIDTH-1], box_min[a]} + {box_max[a][COORD_WIDTH-1], box_max[a]};
			d = {box_max[a][COORD_WIDTH-1], box_max[a]} - {box_min[a][COORD_WIDTH-1], box_min[a]};
			center_n[a] = s[COORD_WIDTH:1];
			ext_n[a]    = d[COORD_WIDTH-1:0];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (sq_cnt_q)
			2'd0:    mul_op = ext_q[0];
			2'd1:    mul_op = ext_q[1];
			2'd2:    mul_op = ext_q[2];
			default: mul_op = '0;
		endcase
	end

	// one restoring square root step
	assign rem_n = {rem_q[RemWidth-3:0], sum_q[SumWidth-1 -: 2]};
	assign trial = {root_q, 2'b01};

	// clamp to one unit
	assign diag_n = (root_q < DiagMin) ? DiagMin : root_q;

	// sequencer
	always_comb begin
		state_n  = state_q;
		load_box = 1'b0;
		load_res = 1'b0;
		case (state_q)
			bcd_pkg::BK_IDLE: begin
				if (box_avail) begin
					load_box = 1'b1;
					state_n  = bcd_pkg::BK_SQUARE;
				end
			end
			bcd_pkg::BK_SQUARE: begin
				if (sq_cnt_q == 2'(bcd_pkg::NumAxes)) state_n = bcd_pkg::BK_ROOT;
			end
			bcd_pkg::BK_ROOT: begin
				if (iter_q == '0) state_n = bcd_pkg::BK_HOLD;
			end
			bcd_pkg::BK_HOLD: begin
				if (!res_valid_q || res_pop) begin
					load_res = 1'b1;
					state_n  = bcd_pkg::BK_IDLE;
				end
			end
			default: state_n = bcd_pkg::BK_IDLE;
		endcase
	end

	assign box_pop   = load_box;
	assign res_valid = res_valid_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcd_pkg::BK_IDLE;
			sq_cnt_q    <= 2'd0;
			iter_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_box) begin
				sq_cnt_q <= 2'd0;
			end else if (state_q == bcd_pkg::BK_SQUARE) begin
				sq_cnt_q <= sq_cnt_q + 2'd1;
			end
			if (state_q == bcd_pkg::BK_SQUARE) begin
				iter_q <= IterWidth'(COORD_WIDTH);
			end else if (state_q == bcd_pkg::BK_ROOT) begin
				iter_q <= iter_q - IterWidth'(1);
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (load_box) begin
			center_q <= center_n;
			ext_q    <= ext_n;
		end
		// squares: multiply one axis, accumulate the previous product
		if (state_q == bcd_pkg::BK_SQUARE) begin
			prod_q <= mul_op * mul_op;
			if (sq_cnt_q == 2'd0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + SumWidth'(prod_q);
			end
			if (sq_cnt_q == 2'(bcd_pkg::NumAxes)) begin
				sum_q  <= acc_q + SumWidth'(prod_q);
				rem_q  <= '0;
				root_q <= '0;
			end
		end
		// root: two radicand bits per cycle
		if (state_q == bcd_pkg::BK_ROOT) begin
			sum_q <= sum_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[COORD_WIDTH-1:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[COORD_WIDTH-1:0], 1'b0};
			end
		end
		if (load_res) begin
			res_center <= center_q;
			res_diag   <= diag_n;
		end
	end

endmodule

[sim/bounding_box_center_diagonal_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounding_box_center_diagonal_top_tb
// Self-checking bench for the bounding box center and diagonal block.
// ----------------------------------------------------------------------------
// A directed table of point sets covers single points, the coordinate
// extremes, the largest box, sub-unit boxes clamped to 1.0 and floor rounding
// of negative centers. Random point sets follow under four idling mixes and
// a long output hold that backs the block up. Every popped box is checked field
// by field against its fixed table row or a local box tracker fed each accepted point.
// ----------------------------------------------------------------------------
module bounding_box_center_diagonal_top_tb;

	localparam int CW           = 24;
	localparam int FB           = 12;
	localparam int AXES         = bcd_pkg::NumAxes;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int TAIL_CYCLES  = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_POINTS = 400;
	localparam int NUM_ROWS     = 24;

	localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
	localparam int UNIT = 1 << FB;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 last;
	} point_t;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
		logic [CW:0]          diag;
	} box_summary_t;

	typedef struct packed {
		point_t       pt;
		logic         fixed;
		box_summary_t res;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic signed [CW-1:0] point_x = '0;
	logic signed [CW-1:0] point_y = '0;
	logic signed [CW-1:0] point_z = '0;
	logic                 last_point = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic signed [CW-1:0] center_x;
	logic signed [CW-1:0] center_y;
	logic signed [CW-1:0] center_z;
	logic [CW:0]          diagonal;

	// tracker state: running box of the open set
	longint box_lo[AXES];
	longint box_hi[AXES];
	bit     box_open = 1'b0;

	box_summary_t pending_boxes[$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int points_sent   = 0;
	int sets_closed   = 0;
	int boxes_checked = 0;
	int fail_cnt      = 0;
	int cycle_cnt     = 0;

	// directed sets: x, y, z, last | fixed | center x, y, z, diagonal
	row_t dir_rows[NUM_ROWS] = '{
		'{'{0, 0, 0, 1'b1}, 1'b1, '{0, 0, 0, UNIT}},
		'{'{MAXC, MAXC, MAXC, 1'b1}, 1'b1, '{MAXC, MAXC, MAXC, UNIT}},
		'{'{MINC, MINC, MINC, 1'b1}, 1'b1, '{MINC, MINC, MINC, UNIT}},
		'{'{MINC, MINC, MINC, 1'b0}, 1'b0, '0},
		'{'{MAXC, MAXC, MAXC, 1'b1}, 1'b0, '0},
		'{'{MAXC, MINC, 0, 1'b0}, 1'b0, '0},
		'{'{MINC, MAXC, 1, 1'b1}, 1'b0, '0},
		'{'{0, 0, 0, 1'b0}, 1'b0, '0},
		'{'{12288, 16384, 0, 1'b0}, 1'b0, '0},
		'{'{0, 0, 49152, 1'b1}, 1'b1, '{6144, 8192, 24576, 53248}},
		'{'{0, 0, 0, 1'b0}, 1'b0, '0},
		'{'{1, 1, 1, 1'b1}, 1'b1, '{0, 0, 0, UNIT}},
		'{'{-3, -3, -3, 1'b0}, 1'b0, '0},
		'{'{0, 0, 0, 1'b1}, 1'b1, '{-2, -2, -2, UNIT}},
		'{'{100, -200, 300, 1'b0}, 1'b0, '0},
		'{'{50, 50, 50, 1'b0}, 1'b0, '0},
		'{'{-1000, 2000, -3000, 1'b0}, 1'b0, '0},
		'{'{7, 8, 9, 1'b1}, 1'b0, '0},
		'{'{0, 0, 0, 1'b0}, 1'b0, '0},
		'{'{4096, 0, 0, 1'b1}, 1'b1, '{2048, 0, 0, UNIT}},
		'{'{0, 0, 0, 1'b0}, 1'b0, '0},
		'{'{4097, 0, 0, 1'b1}, 1'b1, '{2048, 0, 0, 4097}},
		'{'{MAXC, 0, MINC, 1'b0}, 1'b0, '0},
		'{'{MAXC, 0, MINC, 1'b1}, 1'b1, '{MAXC, 0, MINC, UNIT}}
	};

	int send_idle_mix[4] = '{0, 88, 0, 38};
	int stall_mix[4]     = '{0, 0, 88, 38};

	bounding_box_center_diagonal_top #(
		.COORD_WIDTH(CW),
		.FRAC_BITS  (FB)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.last_point(last_point),
		.empty     (empty),
		.pop       (pop),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.diagonal  (diagonal)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bit-serial floor square root of a sum of squares
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned trial;
		int k;
		rem  = 0;
		root = 0;
		for (k = 31; k >= 0; k--) begin
			rem   = (rem << 2) | ((v >> (2 * k)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// grow the box by one point, close it on the last point of the set
	function automatic bit fold_point(input point_t p, output box_summary_t s);
		longint          c[AXES];
		longint          mid[AXES];
		longint unsigned sq_sum;
		longint unsigned ext;
		longint unsigned d;
		int a;
		c[0] = p.x;
		c[1] = p.y;
		c[2] = p.z;
		s    = '0;
		for (a = 0; a < AXES; a++) begin
			if (!box_open || c[a] < box_lo[a])
				box_lo[a] = c[a];
			if (!box_open || c[a] > box_hi[a])
				box_hi[a] = c[a];
		end
		box_open = 1'b1;
		if (!p.last)
			return 1'b0;
		sq_sum = 0;
		for (a = 0; a < AXES; a++) begin
			mid[a] = (box_lo[a] + box_hi[a]) >>> 1;
			ext    = box_hi[a] - box_lo[a];
			sq_sum = sq_sum + ext * ext;
		end
		d = floor_sqrt(sq_sum);
		if (d < UNIT)
			d = UNIT;
		s.cx     = mid[0][CW-1:0];
		s.cy     = mid[1][CW-1:0];
		s.cz     = mid[2][CW-1:0];
		s.diag   = d[CW:0];
		box_open = 1'b0;
		return 1'b1;
	endfunction

	// offer one point, wait for its transfer, record the box it closes
	task automatic send_point(input point_t p, input logic fixed, input box_summary_t fixed_res);
		box_summary_t s;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		point_x    <= p.x;
		point_y    <= p.y;
		point_z    <= p.z;
		last_point <= p.last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		points_sent++;
		if (fold_point(p, s)) begin
			sets_closed++;
			pending_boxes.push_back(fixed ? fixed_res : s);
		end
	endtask

	// coordinate near a set's base, or small, extreme or anywhere
	function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] base);
		logic [CW-1:0] off;
		case ($urandom_range(0, 7))
			0: begin
				return $urandom_range(0, 1) ? MAXC : MINC;
			end
			1: begin
				return CW'($urandom);
			end
			2: begin
				off = CW'($urandom_range(0, 32767));
				return off - CW'(16384);
			end
			default: begin
				off = CW'($urandom_range(0, 8191));
				return base + off - CW'(4096);
			end
		endcase
	endfunction

	// one random point set, mostly short, now and then long
	task automatic send_random_set();
		logic [CW-1:0] base_x;
		logic [CW-1:0] base_y;
		logic [CW-1:0] base_z;
		point_t p;
		int n;
		int i;
		n      = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 24);
		base_x = CW'($urandom);
		base_y = CW'($urandom);
		base_z = CW'($urandom);
		for (i = 0; i < n; i++) begin
			p.x    = pick_coord(base_x);
			p.y    = pick_coord(base_y);
			p.z    = pick_coord(base_z);
			p.last = (i == n - 1);
			send_point(p, 1'b0, '0);
		end
	endtask

	// stop offering and let every outstanding box come out
	task automatic drain_boxes();
		push <= 1'b0;
		while (pending_boxes.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result check on every output transfer
	always @(posedge clk) begin
		box_summary_t e;
		if (arst_n && pop && !empty) begin
			if (pending_boxes.size() == 0) begin
				$error("unexpected box: center %0d %0d %0d, diagonal %0d",
					center_x, center_y, center_z, diagonal);
				fail_cnt++;
			end else begin
				e = pending_boxes.pop_front();
				boxes_checked++;
				if (center_x !== e.cx) begin
					$error("center_x: expected %0d, got %0d", e.cx, center_x);
					fail_cnt++;
				end
				if (center_y !== e.cy) begin
					$error("center_y: expected %0d, got %0d", e.cy, center_y);
					fail_cnt++;
				end
				if (center_z !== e.cz) begin
					$error("center_z: expected %0d, got %0d", e.cz, center_z);
					fail_cnt++;
				end
				if (diagonal !== e.diag) begin
					$error("diagonal: expected %0d, got %0d", e.diag, diagonal);
					fail_cnt++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("bounding_box_center_diagonal_top: mismatch");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		point_t p;
		int r;
		int ph;
		int mark;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (r = 0; r < NUM_ROWS; r++)
			send_point(dir_rows[r].pt, dir_rows[r].fixed, dir_rows[r].res);
		drain_boxes();

		// random sets under each idling mix
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_idle_mix[ph];
			stall_pct     = stall_mix[ph];
			mark          = points_sent;
			while (points_sent - mark < PHASE_POINTS)
				send_random_set();
			drain_boxes();
		end

		// long output hold while single-point sets keep coming
		send_idle_pct = 0;
		stall_pct     = 20;
		hold_req      = hold_req + 1;
		for (r = 0; r < 30; r++) begin
			p.x    = CW'($urandom);
			p.y    = CW'($urandom);
			p.z    = CW'($urandom);
			p.last = 1'b1;
			send_point(p, 1'b0, '0);
		end
		drain_boxes();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d points in %0d sets sent, %0d boxes checked", points_sent, sets_closed,
			boxes_checked);
		$display("idling mixes: none, sender 88%%, receiver 88%%, both 38%%, plus a %0d-cycle hold",
			HOLD_CYCLES);
		if (fail_cnt == 0)
			$display("bounding_box_center_diagonal_top: match");
		else
			$display("bounding_box_center_diagonal_top: mismatch");
		$finish;
	end

endmodule

[bounding_box_center_diagonal_top.f]
design/bcd_pkg.sv
design/bcd_front.sv
design/bcd_queue.sv
design/bcd_back.sv
design/bounding_box_center_diagonal_top.sv
sim/bounding_box_center_diagonal_top_tb.sv
